### sv/tzfp_pkg.sv
package tzfp_pkg;

    localparam int ZONE_COUNT  = 64;
    localparam int ZONE_IDX_W  = 6;
    localparam int VCOUNT_W    = 7;
    localparam int DIST_W      = 12;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] ST_TRUSTED = 8'd5;
    localparam logic [7:0] ST_LOW_A   = 8'd6;
    localparam logic [7:0] ST_LOW_B   = 8'd9;

    localparam logic [DIST_W-1:0] MAX_VALID_RESET = 12'd4000;
    localparam logic [DIST_W-1:0] SENTINEL_RESET  = 12'd4095;

    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_HEALTH = 2'd1,
        KIND_REJECT = 2'd2
    } frame_kind_t;

    typedef enum logic [1:0] {
        REG_ACCEPT_LOW = 2'd0,
        REG_MAX_VALID  = 2'd1,
        REG_SENTINEL   = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic              accept_low;
        logic [DIST_W-1:0] max_valid_mm;
        logic [DIST_W-1:0] invalid_sentinel;
    } cfg_t;

    typedef struct packed {
        logic        has_data;
        logic [63:0] data_bytes;
        logic        has_tail;
        frame_kind_t tail_kind;
        logic [63:0] tail_bytes;
    } frame_entry_t;

endpackage

### sv/tzfp_if.sv
interface tzfp_zone_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic        read_complete;
    logic        io_ok;
    logic        model_ok;
    logic [7:0]  source;
    logic [7:0]  generation;
    logic [7:0]  status_flags;
    logic [7:0]  chain_pos;
    logic [7:0]  boards_seen;
    logic [7:0]  error_code;
    logic [15:0] distance_mm;
    logic [7:0]  zone_status;

    modport source_mp (
        output valid, op, read_complete, io_ok, model_ok, source, generation,
               status_flags, chain_pos, boards_seen, error_code, distance_mm,
               zone_status,
        input  ready
    );
    modport sink (
        input  valid, op, read_complete, io_ok, model_ok, source, generation,
               status_flags, chain_pos, boards_seen, error_code, distance_mm,
               zone_status,
        output ready
    );
endinterface

interface tzfp_frame_if;
    logic        valid;
    logic        ready;
    logic [1:0]  frame_kind;
    logic [63:0] frame_bytes;
    logic        last_of_read;

    modport source_mp (
        output valid, frame_kind, frame_bytes, last_of_read,
        input  ready
    );
    modport sink (
        input  valid, frame_kind, frame_bytes, last_of_read,
        output ready
    );
endinterface

### sv/tof_zone_grid_frame_packer_core.sv
// Path: a zone's frames pass through the frame queue and the output registers in turn.
// Throughput: one item per cycle; the final zone of a read that also closes a data
// group yields two output frames (data frame, then health frame), absorbed by the
// 4-entry frame queue; zone ready drops only while that queue is full.
// Reset: rst_n clears read state, header fields and the queue, and loads the
// registers to accept_low 0, max_valid_mm 4000, invalid_sentinel 4095.
module tof_zone_grid_frame_packer_core
    import tzfp_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    tzfp_zone_if.sink       zones,
    tzfp_frame_if.source_mp frames,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [3:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);

    logic              accept_low_reg;
    logic [DIST_W-1:0] max_valid_reg;
    logic [DIST_W-1:0] sentinel_reg;
    cfg_t              cfg;
    cfg_reg_t          reg_sel;
    logic              cfg_wr;

    logic              push;
    frame_entry_t      push_entry;
    logic              q_full;
    logic              q_empty;
    logic              pop;
    frame_entry_t      q_data;

    assign pready  = 1'b1;
    assign reg_sel = cfg_reg_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accept_low_reg <= 1'b0;
            max_valid_reg  <= MAX_VALID_RESET;
            sentinel_reg   <= SENTINEL_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (reg_sel)
                REG_ACCEPT_LOW: accept_low_reg <= pwdata[0];
                REG_MAX_VALID:  max_valid_reg  <= pwdata[DIST_W-1:0];
                REG_SENTINEL:   sentinel_reg   <= pwdata[DIST_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_ACCEPT_LOW: prdata = {31'd0, accept_low_reg};
            REG_MAX_VALID:  prdata = {20'd0, max_valid_reg};
            REG_SENTINEL:   prdata = {20'd0, sentinel_reg};
            default:        prdata = 32'd0;
        endcase
    end

    assign cfg.accept_low       = accept_low_reg;
    assign cfg.max_valid_mm     = max_valid_reg;
    assign cfg.invalid_sentinel = sentinel_reg;

    tzfp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .zones      (zones),
        .cfg        (cfg),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    tzfp_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (push_entry),
        .full    (q_full),
        .rd_en   (pop),
        .rd_data (q_data),
        .empty   (q_empty)
    );

    tzfp_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_data  (q_data),
        .q_empty (q_empty),
        .pop     (pop),
        .frames  (frames)
    );

endmodule

### sv/tzfp_front.sv
module tzfp_front
    import tzfp_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    tzfp_zone_if.sink      zones,
    input  cfg_t           cfg,
    input  logic           q_full,
    output logic           push,
    output frame_entry_t   push_entry
);

    logic                  admitted_reg;
    logic [ZONE_IDX_W-1:0] zone_idx_reg;
    logic [VCOUNT_W-1:0]   vcount_reg;
    logic [DIST_W-1:0]     pending_reg [3];
    logic                  hdr_source_reg;
    logic [7:0]            hdr_gen_reg;
    logic [11:0]           hdr_nib_reg;
    logic [7:0]            hdr_err_reg;

    logic                  accept;
    logic                  hdr_ok;
    logic                  low_conf;
    logic                  trusted;
    logic [DIST_W-1:0]     zval;
    logic [VCOUNT_W-1:0]   vcount_next;
    logic                  last;
    logic [1:0]            slot;

    assign zones.ready = !q_full;
    assign accept      = zones.valid && zones.ready;

    assign hdr_ok = zones.read_complete && zones.io_ok && zones.model_ok
                    && (zones.source[7:1] == 7'd0);

    assign low_conf = (zones.zone_status == ST_LOW_A) || (zones.zone_status == ST_LOW_B);
    assign trusted  = (zones.zone_status == ST_TRUSTED) || (low_conf && cfg.accept_low);

    always_comb
    begin
        if (!trusted)
            zval = cfg.invalid_sentinel;
        else if (zones.distance_mm > {4'd0, cfg.max_valid_mm})
            zval = cfg.max_valid_mm;
        else
            zval = zones.distance_mm[DIST_W-1:0];
    end

    assign vcount_next = vcount_reg + VCOUNT_W'(trusted);
    assign last        = (zone_idx_reg == ZONE_IDX_W'(ZONE_COUNT - 1));
    assign slot        = zone_idx_reg[1:0];

    always_comb
    begin
        push_entry.has_data   = admitted_reg && (slot == 2'd3);
        push_entry.data_bytes = {hdr_gen_reg, 3'd0, hdr_source_reg, zone_idx_reg[5:2],
                                 pending_reg[0], pending_reg[1], pending_reg[2], zval};
        push_entry.has_tail   = last;
        if (admitted_reg)
        begin
            push_entry.tail_kind  = KIND_HEALTH;
            push_entry.tail_bytes = {hdr_gen_reg, 3'd0, hdr_source_reg, 4'd0,
                                     1'b0, vcount_next, 4'd0, hdr_nib_reg[11:8],
                                     hdr_nib_reg[7:0], hdr_err_reg, 16'd0};
        end
        else
        begin
            push_entry.tail_kind  = KIND_REJECT;
            push_entry.tail_bytes = 64'd0;
        end
    end

    assign push = accept && zones.op && (push_entry.has_data || push_entry.has_tail);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            admitted_reg   <= 1'b0;
            zone_idx_reg   <= '0;
            vcount_reg     <= '0;
            hdr_source_reg <= 1'b0;
            hdr_gen_reg    <= '0;
            hdr_nib_reg    <= '0;
            hdr_err_reg    <= '0;
        end
        else if (accept)
        begin
            if (!zones.op)
            begin
                admitted_reg <= hdr_ok;
                zone_idx_reg <= '0;
                vcount_reg   <= '0;
                if (hdr_ok)
                begin
                    hdr_source_reg <= zones.source[0];
                    hdr_gen_reg    <= zones.generation;
                    hdr_nib_reg    <= {zones.status_flags[3:0], zones.boards_seen[3:0],
                                       zones.chain_pos[3:0]};
                    hdr_err_reg    <= zones.error_code;
                end
            end
            else if (last)
            begin
                admitted_reg <= 1'b0;
                zone_idx_reg <= '0;
                vcount_reg   <= '0;
            end
            else
            begin
                zone_idx_reg <= zone_idx_reg + ZONE_IDX_W'(1);
                if (admitted_reg)
                    vcount_reg <= vcount_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && zones.op && admitted_reg && (slot != 2'd3))
            pending_reg[slot] <= zval;
    end

endmodule

### sv/tzfp_queue.sv
module tzfp_queue
    import tzfp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  frame_entry_t  wr_data,
    output logic          full,
    input  logic          rd_en,
    output frame_entry_t  rd_data,
    output logic          empty
);

    frame_entry_t           mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W:0]   count_reg;
    logic                   do_wr;
    logic                   do_rd;

    assign full    = (count_reg == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= wr_ptr_reg + QUEUE_PTR_W'(1);
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + QUEUE_PTR_W'(1);
            if (do_wr && !do_rd)
                count_reg <= count_reg + (QUEUE_PTR_W+1)'(1);
            else if (do_rd && !do_wr)
                count_reg <= count_reg - (QUEUE_PTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

### sv/tzfp_back.sv
module tzfp_back
    import tzfp_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  frame_entry_t   q_data,
    input  logic           q_empty,
    output logic           pop,
    tzfp_frame_if.source_mp frames
);

    logic        have_data_reg;
    logic        have_tail_reg;
    logic [63:0] data_bytes_reg;
    frame_kind_t tail_kind_reg;
    logic [63:0] tail_bytes_reg;

    logic fire;
    logic rem_data;
    logic rem_tail;

    assign frames.valid        = have_data_reg || have_tail_reg;
    assign frames.frame_kind   = have_data_reg ? KIND_DATA : tail_kind_reg;
    assign frames.frame_bytes  = have_data_reg ? data_bytes_reg : tail_bytes_reg;
    assign frames.last_of_read = !have_data_reg;

    assign fire     = frames.valid && frames.ready;
    assign rem_data = have_data_reg && !fire;
    assign rem_tail = have_tail_reg && !(fire && !have_data_reg);
    assign pop      = !rem_data && !rem_tail && !q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_data_reg <= 1'b0;
            have_tail_reg <= 1'b0;
        end
        else if (pop)
        begin
            have_data_reg <= q_data.has_data;
            have_tail_reg <= q_data.has_tail;
        end
        else
        begin
            have_data_reg <= rem_data;
            have_tail_reg <= rem_tail;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            data_bytes_reg <= q_data.data_bytes;
            tail_kind_reg  <= q_data.tail_kind;
            tail_bytes_reg <= q_data.tail_bytes;
        end
    end

endmodule
